// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; expects clk_i and rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/wspd_pkg.sv =====
// Types, codes and constants of the wheel speed PID drive.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package wspd_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_SIDE     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HALF_WHEELBASE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_SCALE    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STEP_TIME      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN     = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_INTEGRAL_LIMIT = 3'd7;

  // Reset values
  localparam logic [CfgW-1:0] HalfWheelbaseRst = 16'd9830;
  localparam logic [CfgW-1:0] SpeedScaleRst    = 16'd256;
  localparam logic [CfgW-1:0] StepTimeRst      = 16'd655;
  localparam logic [CfgW-1:0] PropGainRst      = 16'd0;
  localparam logic [CfgW-1:0] IntegGainRst     = 16'd1280;
  localparam logic [CfgW-1:0] DerivGainRst     = 16'd0;
  localparam logic [CfgW-1:0] IntegralLimitRst = 16'd51200;

  // Direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  typedef struct packed {
    logic signed [15:0] linear_speed;
    logic signed [15:0] angular_speed;
    logic signed [15:0] measured_speed;
  } in_t;

  typedef struct packed {
    logic [1:0] direction;
    logic       direction_pin;
    logic [7:0] pwm_duty;
  } out_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_TURN,
    MUL_DEM,
    MUL_INT,
    MUL_P,
    MUL_I,
    MUL_D
  } mul_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TURN,
    ST_FLOOR,
    ST_DEM,
    ST_ERR,
    ST_INT,
    ST_CLAMP,
    ST_PI,
    ST_PD,
    ST_SUM,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic    ld_in;
    mul_op_e mul_op;
    logic    ld_floor;
    logic    ld_err;
    logic    ld_isum;
    logic    acc_init;
    logic    acc_add;
    logic    acc_add_sh;
    logic    ld_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/wspd_ctrl.sv =====
// Sequencer of the wheel speed PID drive: steps one control tick through
// the shared multiplier. Depends on wspd_pkg.
`timescale 1ns / 1ps

module wspd_ctrl import wspd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_TURN;
      ST_TURN:  state_d = ST_FLOOR;
      ST_FLOOR: state_d = ST_DEM;
      ST_DEM:   state_d = ST_ERR;
      ST_ERR:   state_d = ST_INT;
      ST_INT:   state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_PI;
      ST_PI:    state_d = ST_PD;
      ST_PD:    state_d = ST_SUM;
      ST_SUM:   state_d = ST_FIN;
      ST_FIN:   if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.mul_op = MUL_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.ld_in  = in_valid_i;
      end
      ST_TURN:  cmd_o.mul_op = MUL_TURN;
      ST_FLOOR: cmd_o.ld_floor = 1'b1;
      ST_DEM:   cmd_o.mul_op = MUL_DEM;
      ST_ERR:   cmd_o.ld_err = 1'b1;
      ST_INT:   cmd_o.mul_op = MUL_INT;
      ST_CLAMP: begin
        // integral clamp and the proportional product share this cycle
        cmd_o.ld_isum = 1'b1;
        cmd_o.mul_op  = MUL_P;
      end
      ST_PI: begin
        cmd_o.acc_init = 1'b1;
        cmd_o.mul_op   = MUL_I;
      end
      ST_PD: begin
        cmd_o.acc_add = 1'b1;
        cmd_o.mul_op  = MUL_D;
      end
      ST_SUM: cmd_o.acc_add_sh = 1'b1;
      ST_FIN: cmd_o.ld_out = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/wspd_datapath.sv =====
// Datapath of the wheel speed PID drive: configuration registers, shared
// multiplier, PID state and output register. Depends on wspd_pkg.
`timescale 1ns / 1ps

module wspd_datapath import wspd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  in_t                in_data_i,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o
);

  // Configuration registers
  logic            right_side_q;
  logic [CfgW-1:0] hwb_q, scale_q, step_q, kp_q, ki_q, kd_q, ilim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_side_q <= 1'b0;
      hwb_q        <= HalfWheelbaseRst;
      scale_q      <= SpeedScaleRst;
      step_q       <= StepTimeRst;
      kp_q         <= PropGainRst;
      ki_q         <= IntegGainRst;
      kd_q         <= DerivGainRst;
      ilim_q       <= IntegralLimitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RIGHT_SIDE:     right_side_q <= cfg_data_i[0];
        CFG_HALF_WHEELBASE: hwb_q        <= cfg_data_i;
        CFG_SPEED_SCALE:    scale_q      <= cfg_data_i;
        CFG_STEP_TIME:      step_q       <= cfg_data_i;
        CFG_PROP_GAIN:      kp_q         <= cfg_data_i;
        CFG_INTEG_GAIN:     ki_q         <= cfg_data_i;
        CFG_DERIV_GAIN:     kd_q         <= cfg_data_i;
        CFG_INTEGRAL_LIMIT: ilim_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latched input beat
  logic signed [15:0] lin_q, ang_q, spd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      lin_q <= in_data_i.linear_speed;
      ang_q <= in_data_i.angular_speed;
      spd_q <= in_data_i.measured_speed;
    end
  end

  // Working registers
  logic [31:0]        fmag_q;
  logic               neg_q;
  logic signed [17:0] err_q;
  logic               dzero_q;
  logic signed [21:0] isum_q;
  logic signed [39:0] acc_q;

  // PID state
  logic signed [21:0] integ_q;
  logic signed [17:0] prev_q;

  // Shared multiplier
  logic signed [32:0] mul_a;
  logic signed [22:0] mul_b;
  logic signed [55:0] prod_q;
  logic signed [18:0] diff;

  assign diff = {err_q[17], err_q} - {prev_q[17], prev_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_op)
      MUL_TURN: begin
        mul_a = {17'd0, hwb_q};
        mul_b = {{7{ang_q[15]}}, ang_q};
      end
      MUL_DEM: begin
        mul_a = {1'b0, fmag_q};
        mul_b = {7'd0, scale_q};
      end
      MUL_INT: begin
        mul_a = {17'd0, step_q};
        mul_b = {{5{err_q[17]}}, err_q};
      end
      MUL_P: begin
        mul_a = {17'd0, kp_q};
        mul_b = {{5{err_q[17]}}, err_q};
      end
      MUL_I: begin
        mul_a = {17'd0, ki_q};
        mul_b = {isum_q[21], isum_q};
      end
      MUL_D: begin
        mul_a = {17'd0, kd_q};
        mul_b = {{4{diff[18]}}, diff};
      end
      MUL_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_op != MUL_NONE) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // Floor speed scaled down by 2^8: linear*2^16 +/- angular*half_wheelbase
  logic signed [33:0] turn_ext, floor_spd;

  assign turn_ext  = {prod_q[32], prod_q[32:0]};
  assign floor_spd = {{2{lin_q[15]}}, lin_q, 16'd0}
                   + (right_side_q ? -turn_ext : turn_ext);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_floor) begin
      neg_q  <= floor_spd[33];
      fmag_q <= floor_spd[33] ? 32'(-floor_spd) : floor_spd[31:0];
    end
  end

  // Demand magnitude, saturated to 16 bits, and error against |measured|
  logic [23:0] dem_hi;
  logic [15:0] dmag;
  logic [16:0] smag;

  assign dem_hi = prod_q[47:24];
  assign dmag   = (|dem_hi[23:16]) ? 16'hFFFF : dem_hi[15:0];
  assign smag   = spd_q[15] ? 17'(-{spd_q[15], spd_q}) : {1'b0, spd_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_err) begin
      err_q   <= $signed({2'b00, dmag}) - $signed({1'b0, smag});
      dzero_q <= (dmag == 16'd0);
    end
  end

  // Integral step truncated toward zero, then clamped to +/- limit*16
  logic signed [33:0] int_prod, int_rnd;
  logic signed [22:0] int_inc;
  logic signed [23:0] int_sum, int_lim;

  assign int_prod = prod_q[33:0];
  assign int_rnd  = int_prod + (int_prod[33] ? 34'sd4095 : 34'sd0);
  assign int_inc  = 23'(int_rnd >>> 12);
  assign int_sum  = {{2{integ_q[21]}}, integ_q} + {int_inc[22], int_inc};
  assign int_lim  = {4'd0, ilim_q, 4'd0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_isum) begin
      priority if (int_sum > int_lim) begin
        isum_q <= int_lim[21:0];
      end else if (int_sum < -int_lim) begin
        isum_q <= 22'(-int_lim);
      end else begin
        isum_q <= int_sum[21:0];
      end
    end
  end

  // PID accumulator in Q.20
  always_ff @(posedge clk_i) begin
    priority if (cmd_i.acc_init) begin
      acc_q <= {prod_q[35:0], 4'd0};
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q[39:0];
    end else if (cmd_i.acc_add_sh) begin
      acc_q <= acc_q + {prod_q[35:0], 4'd0};
    end
  end

  logic [7:0] duty;

  assign duty = acc_q[39]          ? 8'd0   :
                (|acc_q[38:28])    ? 8'd255 : acc_q[27:20];

  // State update and output register
  logic out_valid_q;
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ld_out) begin
        prev_q      <= err_q;
        integ_q     <= dzero_q ? '0 : isum_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      out_q.direction     <= dzero_q ? DIR_STOP : (neg_q ? DIR_REV : DIR_FWD);
      out_q.direction_pin <= !dzero_q && neg_q;
      out_q.pwm_duty      <= dzero_q ? 8'd0 : duty;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

// ===== hw/rtl/wheel_speed_pid_drive.sv =====
// Top level of the wheel speed PID drive: sequencer plus datapath.
// Depends on wspd_pkg, wspd_ctrl and wspd_datapath.
`timescale 1ns / 1ps

// Usage:
// - Input channel (in_valid_i / in_ready_o / in_data_i): one beat per control
//   tick, carrying commanded linear and angular speed and measured encoder
//   speed, all signed Q8.8.
// - Output channel (out_valid_o / out_ready_i / out_data_o): one beat per
//   input beat with direction, direction pin level and PWM duty.
// - Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
//   always ready; write only while no tick is in flight.
// - Sequencing: the six products of a tick go one after another through a
//   single 33x23 multiplier, and one tick is worked at a time.
// - Receiver stall: the finished result sits in the output register; the
//   next input beat is taken meanwhile, and its result waits in the last
//   step until the output register frees up.
// - Reset: configuration returns to its defaults, the integral and the last
//   error clear, and no result is pending.
module wheel_speed_pid_drive import wspd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  wspd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wspd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/wspd_checker.sv =====
// Port-level checks of the wheel speed PID drive, bound to the top level.
// Depends on wspd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wspd_checker import wspd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // A stalled result beat holds
  `ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "output beat changed while stalled")

  // Direction pin follows the direction code
  `ASSERT_CLK(a_pin_match, out_valid_o |-> (out_data_o.direction_pin == (out_data_o.direction == DIR_REV)), "direction pin disagrees with direction")

  // Stopped means no drive and never the unused code
  `ASSERT_CLK(a_stop_coast, out_valid_o && (out_data_o.direction == DIR_STOP || out_data_o.direction == 2'd3) |-> out_data_o.direction == DIR_STOP && out_data_o.pwm_duty == 8'd0, "stopped wheel with drive or bad code")

  // A taken tick blocks input and cannot produce a result on the next edge
  `ASSERT_CLK(a_busy_after_take, in_valid_i && in_ready_o |=> !in_ready_o && !$rose(out_valid_o), "tick not held busy after acceptance")

endmodule

bind wheel_speed_pid_drive wspd_checker u_wspd_checker (.*);

// ===== sim/tb_top.sv =====
// Testbench for the wheel speed PID drive: random and directed control ticks, checked
// beat by beat against an in-bench predictor of the demand, PID and duty arithmetic.
// Depends on wspd_pkg and wheel_speed_pid_drive.
`timescale 1ns / 1ps

module tb_top;
  import wspd_pkg::*;

  localparam int unsigned CfgCount   = 8;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CycleLimit = 400000;

  typedef logic [CfgW-1:0] cfg_set_t [CfgCount];
  typedef enum int {PROF_TUNED, PROF_MAX, PROF_ZERO} profile_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_t                in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_t               out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i  = '0;

  // Predictor copy of the registers and the controller state
  cfg_set_t cfg_val = '{16'd0, HalfWheelbaseRst, SpeedScaleRst, StepTimeRst,
                        PropGainRst, IntegGainRst, DerivGainRst, IntegralLimitRst};
  longint integ_acc = 0;
  longint last_err  = 0;

  out_t expected_duty_q [$];
  int   tx_idle_pct   = 0;
  int   rx_idle_pct   = 0;
  bit   rx_hold       = 1'b0;
  event hold_off_ev;
  int   fail_count    = 0;
  int   ticks_sent    = 0;
  int   results_seen  = 0;
  int   cycle_count   = 0;

  wheel_speed_pid_drive u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint shift_toward_zero(longint v, int k);
    return (v < 0) ? -((-v) >>> k) : (v >>> k);
  endfunction

  // Advance the controller state by one tick and return the beat it should produce.
  function automatic out_t drive_step(in_t tick);
    longint lin, ang, msr, turn, floor_q32, floor_mag, demand, meas_mag;
    longint err, isum, lim, pid, duty;
    logic [1:0] dir;
    out_t res;
    lin = longint'($signed(tick.linear_speed));
    ang = longint'($signed(tick.angular_speed));
    msr = longint'($signed(tick.measured_speed));
    turn = ang * longint'(cfg_val[CFG_HALF_WHEELBASE]) * 256;
    floor_q32 = lin * 64'sd16777216 + (cfg_val[CFG_RIGHT_SIDE][0] ? -turn : turn);
    floor_mag = (floor_q32 < 0) ? -floor_q32 : floor_q32;
    demand = (floor_mag * longint'(cfg_val[CFG_SPEED_SCALE])) >>> 32;
    if (demand > 65535) demand = 65535;
    if (demand == 0) dir = DIR_STOP;
    else if (floor_q32 < 0) dir = DIR_REV;
    else dir = DIR_FWD;
    meas_mag = (msr < 0) ? -msr : msr;
    err = demand - meas_mag;
    isum = integ_acc + shift_toward_zero(err * longint'(cfg_val[CFG_STEP_TIME]), 12);
    lim = longint'(cfg_val[CFG_INTEGRAL_LIMIT]) * 16;
    if (isum > lim) isum = lim;
    if (isum < -lim) isum = -lim;
    pid = longint'(cfg_val[CFG_PROP_GAIN]) * err * 16
        + longint'(cfg_val[CFG_INTEG_GAIN]) * isum
        + longint'(cfg_val[CFG_DERIV_GAIN]) * (err - last_err) * 16;
    duty = shift_toward_zero(pid, 20);
    if (duty < 0) duty = 0;
    if (duty > 255) duty = 255;
    last_err = err;
    integ_acc = (dir == DIR_STOP) ? 0 : isum;
    res.direction     = dir;
    res.direction_pin = (dir == DIR_REV);
    res.pwm_duty      = (dir == DIR_STOP) ? 8'd0 : 8'(duty);
    return res;
  endfunction

  function automatic in_t make_tick(int lin, int ang, int msr);
    in_t t;
    t.linear_speed   = 16'(lin);
    t.angular_speed  = 16'(ang);
    t.measured_speed = 16'(msr);
    return t;
  endfunction

  // Plausible speeds in half the ticks, raw noise in most others, and a share of stop commands.
  function automatic in_t random_tick();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return make_tick($urandom, $urandom, $urandom);
    if (pick < 9) begin
      return make_tick(int'($urandom_range(0, 1536)) - 768, int'($urandom_range(0, 1536)) - 768,
                       int'($urandom_range(0, 8192)) - 4096);
    end
    return make_tick(0, $urandom_range(0, 1), $urandom);
  endfunction

  function automatic cfg_set_t pick_profile(profile_e kind);
    cfg_set_t s;
    case (kind)
      PROF_MAX: begin
        foreach (s[i]) s[i] = '1;
      end
      PROF_ZERO: begin
        foreach (s[i]) s[i] = '0;
        s[CFG_SPEED_SCALE] = CfgW'($urandom_range(1, 2048));
      end
      default: begin
        s[CFG_RIGHT_SIDE]     = CfgW'($urandom);
        s[CFG_HALF_WHEELBASE] = CfgW'($urandom);
        s[CFG_SPEED_SCALE]    = CfgW'($urandom_range(64, 2048));
        s[CFG_STEP_TIME]      = CfgW'($urandom);
        s[CFG_PROP_GAIN]      = CfgW'($urandom_range(0, 4096));
        s[CFG_INTEG_GAIN]     = CfgW'($urandom_range(0, 4096));
        s[CFG_DERIV_GAIN]     = CfgW'($urandom_range(0, 1024));
        s[CFG_INTEGRAL_LIMIT] = $urandom_range(0, 1) ? CfgW'($urandom_range(0, 2048))
                                                     : CfgW'($urandom);
      end
    endcase
    return s;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_val[idx] = (idx == CFG_RIGHT_SIDE) ? CfgW'(data[0]) : data;
  endtask

  task automatic load_config(cfg_set_t s);
    for (int i = 0; i < CfgCount; i++) write_reg(CfgIdxW'(i), s[i]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_tick(in_t tick);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= tick;
    do @(posedge clk_i); while (!in_ready_o);
    expected_duty_q.push_back(drive_step(tick));
    ticks_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_duty_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    cfg_set_t s;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // reset defaults: stop, truncation to stop, smallest demand, field extremes
    send_tick(make_tick(0, 0, 0));
    send_tick(make_tick(0, 1, 0));
    send_tick(make_tick(1, 0, 0));
    send_tick(make_tick(-1, 0, 0));
    send_tick(make_tick(32767, 0, -32768));
    send_tick(make_tick(-32768, 0, 32767));
    send_tick(make_tick(0, 32767, 0));
    send_tick(make_tick(0, -32768, -1));
    send_tick(make_tick(256, 0, 256));
    stop_sending();
    wait_drained();
    // saturate demand, right side, frozen integral, negative PID sum
    s = cfg_val;
    s[CFG_RIGHT_SIDE]     = 16'd1;
    s[CFG_SPEED_SCALE]    = '1;
    s[CFG_STEP_TIME]      = '0;
    s[CFG_PROP_GAIN]      = '1;
    s[CFG_DERIV_GAIN]     = '1;
    s[CFG_INTEGRAL_LIMIT] = '0;
    load_config(s);
    send_tick(make_tick(32767, -32768, 0));
    send_tick(make_tick(-32768, 32767, -32768));
    send_tick(make_tick(1, 0, 32767));
    send_tick(make_tick(0, 0, 5));
    stop_sending();
    wait_drained();
    // integral only: wind up, then clear it with a stop
    s[CFG_RIGHT_SIDE]     = 16'd0;
    s[CFG_SPEED_SCALE]    = 16'd256;
    s[CFG_STEP_TIME]      = '1;
    s[CFG_PROP_GAIN]      = '0;
    s[CFG_INTEG_GAIN]     = '1;
    s[CFG_DERIV_GAIN]     = '0;
    s[CFG_INTEGRAL_LIMIT] = '1;
    load_config(s);
    send_tick(make_tick(512, 0, 0));
    send_tick(make_tick(512, 0, 0));
    send_tick(make_tick(512, 0, 0));
    send_tick(make_tick(-512, 0, 32767));
    send_tick(make_tick(0, 0, 0));
    send_tick(make_tick(512, 0, 0));
    send_tick(make_tick(1, 0, -1));
    stop_sending();
  endtask

  task automatic test_random_sweep(int tx_pct, int rx_pct, int phases, int per_phase);
    profile_e kind;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int p = 0; p < phases; p++) begin
      wait_drained();
      kind = (p % 4 == 1) ? PROF_MAX : (p % 4 == 3) ? PROF_ZERO : PROF_TUNED;
      load_config(pick_profile(kind));
      for (int n = 0; n < per_phase; n++) send_tick(random_tick());
      stop_sending();
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_drained();
    load_config(pick_profile(PROF_TUNED));
    // hold the output while ticks keep coming, so the input stalls
    -> hold_off_ev;
    for (int n = 0; n < 40; n++) send_tick(random_tick());
    stop_sending();
    wait_drained();
    rx_idle_pct = 30;
    for (int n = 0; n < 20; n++) send_tick(random_tick());
    stop_sending();
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    forever begin
      @(hold_off_ev);
      rx_hold = 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      rx_hold = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_duty_q.size() == 0) begin
        $error("unexpected result beat: direction %0d pin %0d duty %0d",
               out_data_o.direction, out_data_o.direction_pin, out_data_o.pwm_duty);
        fail_count++;
      end else begin
        want = expected_duty_q.pop_front();
        if (out_data_o.direction !== want.direction) begin
          $error("direction: expected %0d, got %0d", want.direction, out_data_o.direction);
          fail_count++;
        end
        if (out_data_o.direction_pin !== want.direction_pin) begin
          $error("direction_pin: expected %0d, got %0d",
                 want.direction_pin, out_data_o.direction_pin);
          fail_count++;
        end
        if (out_data_o.pwm_duty !== want.pwm_duty) begin
          $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, out_data_o.pwm_duty);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_sweep(18, 68, 4, 110);
    test_random_sweep(68, 18, 4, 110);
    test_random_sweep(0, 0, 4, 110);
    test_backpressure();
    wait_drained();
    repeat (30) @(posedge clk_i);
    $display("%0d ticks driven (directed corners, swept register settings, long output stall)",
             ticks_sent);
    $display("%0d result beats checked, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/wspd_pkg.sv
hw/rtl/wspd_ctrl.sv
hw/rtl/wspd_datapath.sv
hw/rtl/wheel_speed_pid_drive.sv
hw/rtl/wspd_checker.sv
sim/tb_top.sv
